// ===== hw/rtl/pssv_pkg.sv =====
`timescale 1ns / 1ps
// Package for the polyphonic sine voice block: request codes, FSM state type,
// envelope constants, semitone ratios and the sine table function. No dependencies.
package pssv_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_NOTE_ON = 2'd1,
    REQ_NOTE_OFF = 2'd2,
    REQ_ALL_OFF = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_STEP,
    ST_NOTE_WR,
    ST_TICK_RD,
    ST_TICK_ENV,
    ST_TICK_TAB,
    ST_TICK_MUL,
    ST_TICK_ACC,
    ST_OUT
  } state_t;

  localparam logic [15:0] ATTACK_STEP   = 16'd262;
  localparam logic [15:0] DECAY_MUL     = 16'd65208;
  localparam logic [15:0] RELEASE_FLOOR = 16'd7;
  localparam logic [15:0] VEL_MIN       = 16'd1311;
  localparam logic [15:0] VEL_MAX       = 16'd11796;
  localparam logic [15:0] TARGET_MUL    = 16'd52429;

  localparam logic [63:0] POLY_A1 = 64'd1686629713;
  localparam logic [63:0] POLY_A3 = 64'd693598668;
  localparam logic [63:0] POLY_A5 = 64'd85569306;
  localparam logic [63:0] POLY_A7 = 64'd5026995;
  localparam logic [63:0] POLY_A9 = 64'd172272;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;

  function automatic logic [31:0] semitone_ratio(input logic [3:0] s);
    logic [31:0] r;
    begin
      unique case (s)
        4'd0:  r = 32'd1073741824;
        4'd1:  r = 32'd1137589835;
        4'd2:  r = 32'd1205234447;
        4'd3:  r = 32'd1276901417;
        4'd4:  r = 32'd1352829926;
        4'd5:  r = 32'd1433273380;
        4'd6:  r = 32'd1518500250;
        4'd7:  r = 32'd1608794974;
        4'd8:  r = 32'd1704458901;
        4'd9:  r = 32'd1805811301;
        4'd10: r = 32'd1913190429;
        4'd11: r = 32'd2026954652;
        default: r = 32'd1073741824;
      endcase
      semitone_ratio = r;
    end
  endfunction

  // elaboration-time table entry; u in quarter cycles Q2.30
  function automatic logic signed [15:0] sine_entry(input int unsigned i, input int unsigned n);
    logic [63:0] u, r, z, z2, p;
    logic [1:0] quad;
    begin
      u = (64'(i) << 32) / 64'(n);
      quad = u[31:30];
      r = u & (Q30_ONE - 64'd1);
      z = quad[0] ? (Q30_ONE - r) : r;
      z2 = (z * z) >> 30;
      p = POLY_A7 - ((z2 * POLY_A9) >> 30);
      p = POLY_A5 - ((z2 * p) >> 30);
      p = POLY_A3 - ((z2 * p) >> 30);
      p = POLY_A1 - ((z2 * p) >> 30);
      p = (z * p) >> 30;
      p = (p + 64'd16384) >> 15;
      if (p > 64'd32767) p = 64'd32767;
      sine_entry = quad[1] ? -16'(p) : 16'(p);
    end
  endfunction

endpackage

// ===== hw/rtl/pssv_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and samples.
// Depends on nothing.
interface pssv_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] note;
  logic [15:0] velocity;
  modport source (output valid, req_type, note, velocity, input ready);
  modport sink   (input valid, req_type, note, velocity, output ready);
endinterface

interface pssv_smp_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample_out;
  logic              saturated;
  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

// ===== hw/rtl/polyphonic_sine_synth_voices.sv =====
`timescale 1ns / 1ps
// Polyphonic sine voices: top level with voice memory and sequencer.
// Depends on pssv_pkg, pssv_if, pssv_sine_rom.
//
// Channels: req (sink) carries req_type/note/velocity words; smp (source)
// returns one sample word per sample tick, nothing for note requests.
// cfg_we/cfg_data write the A4 phase increment (Q0.32); the user must write it
// only while idle, as the block itself does not enforce this. Voice state lives
// in one memory of NUM_VOICES entries, read through a register. A tick walks
// each voice through ST_TICK_RD, ST_TICK_ENV, ST_TICK_TAB, ST_TICK_MUL and
// ST_TICK_ACC, then ST_OUT. Note-on scans all voices (ST_SCAN_RD, ST_SCAN), then
// computes the step (ST_STEP) and writes the voice; note-off and all-off only scan.
// The sample sits in an output register; the next request is taken while it
// waits, but a following tick holds until the output register is free.
// Reset (sync, rst high) clears control and marks every voice inactive and
// not releasing via flip-flop flags; the memory holds note, step, phase, level, target.
// A stalled receiver only stalls a later tick.
module polyphonic_sine_synth_voices #(
  parameter int unsigned NUM_VOICES = 8,
  parameter int unsigned SINE_TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  pssv_req_if.sink    req,
  pssv_smp_if.source  smp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);
  import pssv_pkg::*;

  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned CW = $clog2(NUM_VOICES + 1);
  localparam int unsigned AW = $clog2(SINE_TABLE_SIZE);

  typedef struct packed {
    logic [6:0]  note;
    logic [31:0] step;
    logic [31:0] phase;
    logic [15:0] level;
    logic [15:0] target;
  } voice_t;

  voice_t mem [NUM_VOICES];
  voice_t rd;
  logic [VW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  voice_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  logic [NUM_VOICES-1:0] active, releasing;
  logic [31:0] a4_inc;
  state_t state, state_next;
  logic [CW-1:0] idx;
  logic [1:0] rtype;
  logic [6:0] rnote;
  logic [15:0] rtarget;
  logic found_same, found_free;
  logic [VW-1:0] same_v, free_v;
  logic [31:0] prod;
  logic [3:0] semi;
  logic [3:0] oct;
  logic [7:0] n_p3;
  logic [15:0] n_q;
  logic [3:0] n_oct;
  logic [15:0] lvl;
  logic [16:0] nl;
  logic [31:0] dec;
  logic [31:0] x_frac;
  logic signed [15:0] t0, t1;
  logic signed [16:0] diff;
  logic signed [49:0] interp;
  logic signed [16:0] val;
  logic signed [33:0] vprod;
  logic signed [22:0] acc;
  logic               alive;
  logic               out_valid;
  logic signed [15:0] out_s;
  logic               out_sat;
  logic [CW-1:0] idx_p1;
  logic [VW-1:0] iv;
  logic [AW-1:0] i0, i1;

  assign idx_p1 = idx + CW'(1);
  assign iv = idx[VW-1:0];

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req.valid) begin
        if (req.req_type == REQ_TICK) state_next = out_valid ? ST_IDLE : ST_TICK_RD;
        else state_next = ST_SCAN_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN;
      ST_SCAN: state_next = (idx_p1 == CW'(NUM_VOICES)) ?
                            ((rtype == REQ_NOTE_ON) ? ST_STEP : ST_IDLE) : ST_SCAN_RD;
      ST_STEP: state_next = ST_NOTE_WR;
      ST_NOTE_WR: state_next = ST_IDLE;
      ST_TICK_RD: state_next = ST_TICK_ENV;
      ST_TICK_ENV: state_next = ST_TICK_TAB;
      ST_TICK_TAB: state_next = ST_TICK_MUL;
      ST_TICK_MUL: state_next = ST_TICK_ACC;
      ST_TICK_ACC: state_next = (idx_p1 == CW'(NUM_VOICES)) ? ST_OUT : ST_TICK_RD;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs / memory control
  always_comb begin
    req.ready = 1'b0;
    rd_addr = iv;
    wr_en = 1'b0;
    wr_addr = iv;
    wr_data = rd;
    unique case (state)
      ST_IDLE: req.ready = (req.req_type != REQ_TICK) || !out_valid;
      ST_NOTE_WR: begin
        wr_en = 1'b1;
        wr_addr = found_same ? same_v : (found_free ? free_v : '0);
        wr_data.note = rnote;
        wr_data.step = prod;
        wr_data.phase = '0;
        wr_data.level = '0;
        wr_data.target = rtarget;
      end
      ST_TICK_ACC: begin
        wr_en = active[iv];
        wr_data.level = lvl;
        wr_data.phase = rd.phase + (alive ? rd.step : 32'd0);
      end
      default: ;
    endcase
  end

  assign nl = {1'b0, rd.level} + {1'b0, ATTACK_STEP};
  assign dec = rd.level * DECAY_MUL;
  assign x_frac = rd.phase << AW;
  assign i0 = rd.phase[31 -: AW];
  assign i1 = i0 + AW'(1);

  // octave = (note + 3) / 12 by reciprocal multiply, exact up to 130
  assign n_p3 = 8'(rnote) + 8'd3;
  assign n_q = 16'(n_p3) * 16'd171;
  assign n_oct = n_q[14:11];

  pssv_sine_rom #(.TABLE_SIZE(SINE_TABLE_SIZE), .AW(AW)) u_rom (
    .clk(clk), .addr0(i0), .addr1(i1), .data0(t0), .data1(t1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= '0;
      releasing <= '0;
      a4_inc <= 32'd39370534;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) a4_inc <= cfg_data;
      if (smp.valid && smp.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          found_same <= 1'b0;
          found_free <= 1'b0;
          if (req.valid && req.ready) begin
            rtype <= req.req_type;
            rnote <= req.note;
            rtarget <= 16'(((32'(req.velocity < VEL_MIN ? VEL_MIN :
                        (req.velocity > VEL_MAX ? VEL_MAX : req.velocity)) * TARGET_MUL)
                        + 32'd32768) >> 16);
            acc <= '0;
            if (req.req_type == REQ_ALL_OFF) releasing <= '1;
          end
        end
        ST_SCAN: begin
          idx <= idx_p1;
          if (rtype == REQ_NOTE_OFF && active[iv] && rd.note == rnote) releasing[iv] <= 1'b1;
          if (!found_same && active[iv] && rd.note == rnote) begin
            found_same <= 1'b1; same_v <= iv;
          end
          if (!found_free && !active[iv]) begin
            found_free <= 1'b1; free_v <= iv;
          end
        end
        ST_STEP: begin
          semi <= 4'(n_p3 - 8'(n_oct) * 8'd12);
          oct  <= n_oct;
        end
        ST_NOTE_WR: begin
          active[wr_addr] <= 1'b1;
          releasing[wr_addr] <= 1'b0;
        end
        ST_TICK_ENV: begin
          if (releasing[iv]) begin
            lvl <= dec[31:16];
            alive <= dec[31:16] >= RELEASE_FLOOR;
          end else begin
            lvl <= (nl < {1'b0, rd.target}) ? nl[15:0] : rd.target;
            alive <= 1'b1;
          end
        end
        ST_TICK_TAB: diff <= 17'(t1) - 17'(t0);
        ST_TICK_MUL: begin
          interp <= (50'(diff) * $signed({1'b0, x_frac}));
        end
        ST_TICK_ACC: begin
          idx <= idx_p1;
          if (active[iv]) begin
            if (!alive) active[iv] <= 1'b0;
            else acc <= acc + 23'(vprod >>> 16);
          end
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          out_sat <= (acc > 23'sd32767) || (acc < -23'sd32768);
          out_s <= (acc > 23'sd32767) ? 16'sh7fff :
                   (acc < -23'sd32768) ? -16'sh8000 : acc[15:0];
        end
        default: ;
      endcase
    end
  end

  // step: floor(a4 * R / 2^(36-k)) mod 2^32, used in ST_NOTE_WR
  logic [63:0] raw;
  assign raw = 64'(a4_inc) * 64'(semitone_ratio(semi));
  assign prod = 32'(raw >> (6'd36 - 6'(oct)));

  assign val = 17'(t0) + 17'(interp >>> 32);
  assign vprod = 34'(val) * $signed({18'd0, lvl});

  assign smp.valid = out_valid;
  assign smp.sample_out = out_s;
  assign smp.saturated = out_sat;

`ifndef SYNTHESIS
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> state == ST_IDLE) else $error("accept outside idle");
  a_wr_note: assert property (@(posedge clk) disable iff (rst)
    state == ST_NOTE_WR |=> active[$past(wr_addr)]) else $error("note-on lost voice");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> !out_valid) else $error("sample overwritten");
`endif
endmodule

// ===== hw/rtl/pssv_sine_rom.sv =====
`timescale 1ns / 1ps
// Dual-read registered sine table, filled at elaboration.
// Depends on pssv_pkg.
module pssv_sine_rom #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned AW = 10
) (
  input  logic                  clk,
  input  logic [AW-1:0]         addr0,
  input  logic [AW-1:0]         addr1,
  output logic signed [15:0]    data0,
  output logic signed [15:0]    data1
);
  import pssv_pkg::*;

  logic signed [15:0] rom [TABLE_SIZE];

  always_comb begin
    for (int unsigned i = 0; i < TABLE_SIZE; i++) rom[i] = sine_entry(i, TABLE_SIZE);
  end

  always_ff @(posedge clk) begin
    data0 <= rom[addr0];
    data1 <= rom[addr1];
  end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for polyphonic_sine_synth_voices: random note/tick words checked
// against an in-bench voice model. Depends on pssv_pkg and pssv_if.
module tb_top;
  import pssv_pkg::*;

  localparam int NV = 8;
  localparam int TSIZE = 1024;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    req_t        kind;
    logic [6:0]  note;
    logic [15:0] vel;
  } req_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sat;
  } smp_word_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [31:0] cfg_data = '0;

  pssv_req_if req ();
  pssv_smp_if smp ();

  polyphonic_sine_synth_voices dut (
    .clk(clk), .rst(rst), .req(req.sink), .smp(smp.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // voice model
  logic [31:0] a4_inc;
  logic        v_on [NV];
  logic        v_rel [NV];
  logic [6:0]  v_note [NV];
  logic [31:0] v_step [NV];
  logic [31:0] v_ph [NV];
  logic [31:0] v_lvl [NV];
  logic [31:0] v_tgt [NV];
  int          sine_rom [TSIZE];

  req_word_t pending_words[$];
  smp_word_t expected_samples[$];
  int errors = 0, n_ticks = 0, n_sat = 0, n_words = 0, idle_cycles = 0;
  bit driving_done = 0, long_stall = 0;
  bit req_taken = 0;

  function automatic int quarter_sine(longint unsigned z);
    longint unsigned z2, p;
    z2 = (z * z) >> 30;
    p = 64'd5026995 - ((z2 * 64'd172272) >> 30);
    p = 64'd85569306 - ((z2 * p) >> 30);
    p = 64'd693598668 - ((z2 * p) >> 30);
    p = 64'd1686629713 - ((z2 * p) >> 30);
    p = (z * p) >> 30;
    p = (p + 64'd16384) >> 15;
    if (p > 64'd32767) p = 64'd32767;
    return int'(p);
  endfunction

  function automatic void build_sine_rom();
    longint unsigned u, r, z;
    int q, s;
    for (int i = 0; i < TSIZE; i++) begin
      u = (64'(i) << 32) / TSIZE;
      q = int'((u >> 30) & 3);
      r = u & 64'h3fff_ffff;
      z = (q & 1) ? (64'h4000_0000 - r) : r;
      s = quarter_sine(z);
      sine_rom[i] = (q & 2) ? -s : s;
    end
  endfunction

  function automatic longint floor_sh(longint v, int k);
    return v >>> k;
  endfunction

  function automatic int interp_sine(logic [31:0] ph);
    logic [41:0] x;
    int i0, i1;
    longint d, f;
    x = 42'(ph) * TSIZE;
    i0 = int'(x[41:32]);
    i1 = (i0 + 1) % TSIZE;
    f = longint'(x[31:0]);
    d = sine_rom[i1] - sine_rom[i0];
    return sine_rom[i0] + int'(floor_sh(d * f, 32));
  endfunction

  function automatic logic [31:0] note_step(logic [6:0] nt);
    int n, k;
    logic [63:0] prod;
    n = int'(nt) + 3;
    k = n / 12;
    prod = 64'(a4_inc) * 64'(semitone_ratio(4'(n % 12)));
    return 32'(prod >> (36 - k));
  endfunction

  function automatic void model_reset();
    a4_inc = 32'd39370534;
    for (int v = 0; v < NV; v++) begin
      v_on[v] = 0; v_rel[v] = 0; v_note[v] = 0; v_step[v] = 0;
      v_ph[v] = 0; v_lvl[v] = 0; v_tgt[v] = 0;
    end
  endfunction

  function automatic void apply_word(req_word_t w);
    int pick;
    logic [31:0] vel;
    int sum;
    smp_word_t o;
    case (w.kind)
      REQ_NOTE_ON: begin
        pick = -1;
        for (int v = 0; v < NV; v++)
          if (pick < 0 && v_on[v] && v_note[v] == w.note) pick = v;
        for (int v = 0; v < NV; v++)
          if (pick < 0 && !v_on[v]) pick = v;
        if (pick < 0) pick = 0;
        vel = w.vel;
        if (vel < VEL_MIN) vel = VEL_MIN;
        if (vel > VEL_MAX) vel = VEL_MAX;
        v_note[pick] = w.note;
        v_step[pick] = note_step(w.note);
        v_ph[pick] = 0;
        v_lvl[pick] = 0;
        v_tgt[pick] = (vel * TARGET_MUL + 32'd32768) >> 16;
        v_on[pick] = 1;
        v_rel[pick] = 0;
      end
      REQ_NOTE_OFF:
        for (int v = 0; v < NV; v++)
          if (v_on[v] && v_note[v] == w.note) v_rel[v] = 1;
      REQ_ALL_OFF:
        for (int v = 0; v < NV; v++) v_rel[v] = 1;
      default: begin
        sum = 0;
        for (int v = 0; v < NV; v++) begin
          if (!v_on[v]) continue;
          if (v_rel[v]) begin
            v_lvl[v] = (v_lvl[v] * DECAY_MUL) >> 16;
            if (v_lvl[v] < RELEASE_FLOOR) begin
              v_on[v] = 0;
              continue;
            end
          end else if (v_lvl[v] + ATTACK_STEP < v_tgt[v]) begin
            v_lvl[v] = v_lvl[v] + ATTACK_STEP;
          end else begin
            v_lvl[v] = v_tgt[v];
          end
          sum += int'(floor_sh(longint'(interp_sine(v_ph[v])) * longint'(v_lvl[v]), 16));
          v_ph[v] = v_ph[v] + v_step[v];
        end
        o.sat = 0;
        if (sum > 32767) begin sum = 32767; o.sat = 1; end
        if (sum < -32768) begin sum = -32768; o.sat = 1; end
        o.sample = 16'(sum);
        expected_samples.push_back(o);
      end
    endcase
  endfunction

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 0;
      req.req_type <= REQ_TICK;
      req.note <= '0;
      req.velocity <= '0;
    end else if (req.valid && !req_taken) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      req.valid <= 0;
    end else if (pending_words.size() > 0) begin
      req_word_t w;
      w = pending_words.pop_front();
      req.valid <= 1;
      req.req_type <= w.kind;
      req.note <= w.note;
      req.velocity <= w.vel;
      if (burst_left <= 0) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      req.valid <= 0;
    end
  end

  // receiver stall pattern plus one long hold-off
  int stall_pat = 0;
  always @(negedge clk) begin
    stall_pat <= stall_pat + 1;
    if (rst) smp.ready <= 0;
    else if (long_stall) smp.ready <= 0;
    else if (stall_pat % 256 < 64) smp.ready <= 1;
    else smp.ready <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk) begin
    req_taken <= req.valid && req.ready;
    if (!rst) begin
      if (req.valid && req.ready) begin
        req_word_t w;
        w.kind = req_t'(req.req_type);
        w.note = req.note;
        w.vel = req.velocity;
        apply_word(w);
        n_words++;
      end
      if (smp.valid && smp.ready) begin
        n_ticks++;
        if (smp.saturated) n_sat++;
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected sample %0d", $time, smp.sample_out);
        end else begin
          smp_word_t e;
          e = expected_samples.pop_front();
          if (e.sample !== smp.sample_out || e.sat !== smp.saturated) begin
            errors++;
            $display("%0t: sample exp %0d sat %0b, got %0d sat %0b", $time,
                     e.sample, e.sat, smp.sample_out, smp.saturated);
          end
        end
      end
      if ((req.valid && req.ready) || (smp.valid && smp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("%0t: watchdog, no progress", $time);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic req_word_t mk(req_t k, int nt, int vl);
    req_word_t w;
    w.kind = k;
    w.note = 7'(nt);
    w.vel = 16'(vl);
    return w;
  endfunction

  function automatic req_word_t rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return mk(REQ_TICK, $urandom, $urandom);
    if (r < 80) return mk(REQ_NOTE_ON, $urandom_range(40, 90), $urandom);
    if (r < 88) return mk(REQ_NOTE_ON, $urandom, $urandom);
    if (r < 98) return mk(REQ_NOTE_OFF, $urandom_range(40, 90), $urandom);
    return mk(REQ_ALL_OFF, $urandom, $urandom);
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || req.valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_a4(logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    a4_inc = val;
  endtask

  logic [31:0] a4_settings [4] = '{32'd39370534, 32'hffff_ffff, 32'd0, 32'h1234_5678};

  initial begin
    build_sine_rom();
    model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: extremes, stealing, releases, loud chord
    pending_words.push_back(mk(REQ_TICK, 0, 0));
    pending_words.push_back(mk(REQ_NOTE_ON, 0, 0));
    pending_words.push_back(mk(REQ_NOTE_ON, 127, 65535));
    pending_words.push_back(mk(REQ_NOTE_ON, 69, 11796));
    pending_words.push_back(mk(REQ_NOTE_ON, 69, 1311));
    for (int i = 0; i < 6; i++)
      pending_words.push_back(mk(REQ_NOTE_ON, 60 + i, 65535));
    pending_words.push_back(mk(REQ_NOTE_ON, 100, 40000));
    for (int i = 0; i < 6; i++) pending_words.push_back(mk(REQ_TICK, 0, 0));
    pending_words.push_back(mk(REQ_NOTE_OFF, 69, 0));
    pending_words.push_back(mk(REQ_NOTE_OFF, 5, 0));
    pending_words.push_back(mk(REQ_ALL_OFF, 0, 0));
    pending_words.push_back(mk(REQ_TICK, 127, 65535));
    drain();

    foreach (a4_settings[s]) begin
      write_a4(a4_settings[s]);
      // long hold-off of the receiver while words are queued
      if (s == 1) begin
        fork
          begin
            long_stall = 1;
            repeat (3000) @(posedge clk);
            long_stall = 0;
          end
        join_none
      end
      for (int i = 0; i < 250; i++) begin
        if (i % 60 == 0)
          for (int j = 0; j < 8; j++)
            pending_words.push_back(mk(REQ_NOTE_ON, $urandom_range(48, 84), 65535));
        else if (i % 60 < 50) pending_words.push_back(rand_word());
        else pending_words.push_back(mk(REQ_TICK, 0, 0));
      end
      // release all voices and tick on so their levels decay
      pending_words.push_back(mk(REQ_ALL_OFF, 0, 0));
      for (int i = 0; i < 40; i++) pending_words.push_back(mk(REQ_TICK, 0, 0));
      drain();
    end

    $display("run: %0d words, %0d samples checked (%0d clipped), 4 A4 settings",
             n_words, n_ticks, n_sat);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
